@@ src/keyboard_display_port_bus_unit_defines.svh @@
// assertion macros for the keyboard and display port bus unit
`ifndef KEYBOARD_DISPLAY_PORT_BUS_UNIT_DEFINES_SVH
`define KEYBOARD_DISPLAY_PORT_BUS_UNIT_DEFINES_SVH

// implication checked outside reset
`define KDP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define KDP_ASSERT_NEXT(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/kdp_pkg.sv @@
// types and constants shared by the keyboard and display port bus unit
package kdp_pkg;

  localparam int ADDR_BITS = 16;
  localparam int RAM_DEPTH = 1 << ADDR_BITS;

  localparam logic [7:0] PORT_PAGE    = 8'hD0;
  localparam logic [5:0] PORT_ROW     = 6'h04;  // low byte 0x10..0x13
  localparam logic [7:0] KEY_RESET    = 8'h20;
  localparam logic [7:0] BIT7         = 8'h80;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [6:0] CHAR_CTRL_MAX = 7'h1F;
  localparam logic [6:0] CHAR_BS      = 7'h08;
  localparam logic [6:0] CHAR_CR      = 7'h0D;
  localparam logic [6:0] CHAR_DEL     = 7'h7F;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_KEY   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PORT_KDATA = 2'd0,
    PORT_KCTRL = 2'd1,
    PORT_DDATA = 2'd2,
    PORT_DCTRL = 2'd3
  } port_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  key_char;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       print_valid;
    logic [6:0] print_char;
  } result_t;

  typedef struct packed {
    op_t                  op;
    logic                 is_port;
    port_t                port;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [7:0]           data;
  } cmd_t;

endpackage

@@ src/kdp_ram.sv @@
// generic single-port ram with registered read
module kdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ src/kdp_front.sv @@
// front end: accepts items, decodes the address and queues commands
module kdp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  kdp_pkg::item_t     item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output kdp_pkg::cmd_t      cmd
);

  kdp_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;
  kdp_pkg::cmd_t decoded;

  // classify the item: port decode needs the full 16-bit address
  always_comb begin
    decoded.op       = kdp_pkg::op_t'(item.func);
    decoded.is_port  = (item.address[15:8] == kdp_pkg::PORT_PAGE) &&
                       (item.address[7:2] == kdp_pkg::PORT_ROW);
    decoded.port     = kdp_pkg::port_t'(item.address[1:0]);
    decoded.ram_addr = item.address[kdp_pkg::ADDR_BITS-1:0];
    decoded.data     = (item.func == kdp_pkg::OP_KEY) ? item.key_char : item.write_data;
  end

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop    = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/kdp_back.sv @@
// back end: port registers, ram access and result queue
module kdp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  kdp_pkg::cmd_t    cmd,
  output logic             empty,
  input  logic             pop,
  output kdp_pkg::result_t result
);

  logic [7:0] key_data, key_data_next;
  logic [7:0] key_control, key_control_next;
  logic [7:0] display_data, display_data_next;
  logic [7:0] display_control, display_control_next;
  logic       key_pending, key_pending_next;
  logic [7:0] key_latch, key_latch_next;

  logic             fire;
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  logic [7:0]       key_up;
  logic [6:0]       disp_char;
  kdp_pkg::result_t res_next;

  // execute stage result register
  logic             r_valid;
  logic             r_is_ram;
  kdp_pkg::result_t r_res;
  kdp_pkg::result_t r_final;
  logic             r_move;

  // result queue
  kdp_pkg::result_t oq [2];
  logic             oq_wr;
  logic             oq_rd;
  logic [1:0]       oq_count;
  logic             do_pop;

  assign r_move    = r_valid && (oq_count != 2'd2);
  assign cmd_ready = !r_valid || r_move;
  assign fire      = cmd_valid && cmd_ready;
  assign ram_we    = fire && (cmd.op == kdp_pkg::OP_WRITE) && !cmd.is_port;
  assign ram_re    = fire && (cmd.op == kdp_pkg::OP_READ) && !cmd.is_port;

  kdp_ram #(
    .WIDTH (8),
    .DEPTH (kdp_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (cmd.ram_addr),
    .wdata (cmd.data),
    .rdata (ram_rdata)
  );

  always_comb begin
    key_data_next        = key_data;
    key_control_next     = key_control;
    display_data_next    = display_data;
    display_control_next = display_control;
    key_pending_next     = key_pending;
    key_latch_next       = key_latch;
    res_next             = '0;
    key_up               = key_latch;
    disp_char            = display_data[6:0];
    if ((key_latch >= kdp_pkg::CHAR_LOWER_A) && (key_latch <= kdp_pkg::CHAR_LOWER_Z)) begin
      key_up = key_latch - kdp_pkg::CASE_OFFSET;
    end
    if (fire) begin
      case (cmd.op)
        kdp_pkg::OP_WRITE: begin
          if (cmd.is_port) begin
            case (cmd.port)
              kdp_pkg::PORT_KDATA: key_data_next        = cmd.data;
              kdp_pkg::PORT_KCTRL: key_control_next     = cmd.data;
              kdp_pkg::PORT_DDATA: display_data_next    = cmd.data | kdp_pkg::BIT7;
              kdp_pkg::PORT_DCTRL: display_control_next = cmd.data;
              default:             key_data_next        = key_data;
            endcase
          end
        end
        kdp_pkg::OP_READ: begin
          if (cmd.is_port) begin
            case (cmd.port)
              kdp_pkg::PORT_KDATA: begin
                res_next.read_data = key_data;
                key_control_next   = key_control & ~kdp_pkg::BIT7;
              end
              kdp_pkg::PORT_KCTRL: res_next.read_data = key_control;
              kdp_pkg::PORT_DDATA: res_next.read_data = display_data;
              kdp_pkg::PORT_DCTRL: res_next.read_data = display_control;
              default:             res_next.read_data = 8'd0;
            endcase
          end
        end
        kdp_pkg::OP_KEY: begin
          key_latch_next   = cmd.data;
          key_pending_next = 1'b1;
        end
        kdp_pkg::OP_TICK: begin
          if (key_pending) begin
            key_pending_next = 1'b0;
            if (!key_control[7]) begin
              key_data_next    = key_up | kdp_pkg::BIT7;
              key_control_next = key_control | kdp_pkg::BIT7;
            end
          end
          if (display_data[7]) begin
            if (((disp_char > kdp_pkg::CHAR_CTRL_MAX) || (disp_char == kdp_pkg::CHAR_BS) ||
                 (disp_char == kdp_pkg::CHAR_CR)) && (disp_char != kdp_pkg::CHAR_DEL)) begin
              res_next.print_valid = 1'b1;
              res_next.print_char  = disp_char;
            end
            display_data_next = display_data & ~kdp_pkg::BIT7;
          end
        end
        default: res_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_data        <= 8'd0;
      key_control     <= 8'd0;
      display_data    <= 8'd0;
      display_control <= 8'd0;
      key_pending     <= 1'b0;
      key_latch       <= kdp_pkg::KEY_RESET;
    end else begin
      key_data        <= key_data_next;
      key_control     <= key_control_next;
      display_data    <= display_data_next;
      display_control <= display_control_next;
      key_pending     <= key_pending_next;
      key_latch       <= key_latch_next;
    end
  end

  // ram data is held by the ram while the result waits here
  always_comb begin
    r_final = r_res;
    if (r_is_ram) begin
      r_final.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r_res    <= res_next;
      r_is_ram <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (cmd_ready) begin
      r_valid <= fire;
    end
  end

  assign empty  = (oq_count == 2'd0);
  assign do_pop = pop && !empty;
  assign result = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (r_move) begin
      oq[oq_wr] <= r_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (r_move) begin
        oq_wr <= ~oq_wr;
      end
      if (do_pop) begin
        oq_rd <= ~oq_rd;
      end
      case ({r_move, do_pop})
        2'b10:   oq_count <= oq_count + 2'd1;
        2'b01:   oq_count <= oq_count - 2'd1;
        default: oq_count <= oq_count;
      endcase
    end
  end

endmodule

@@ src/keyboard_display_port_bus_unit.sv @@
// top level of the keyboard and display port bus unit
//
// input channel: an item (func, address, write_data, key_char) is taken as one beat
//   at a rising edge with push high and full low
// result channel: the oldest result (read_data, print_valid, print_char) shows while
//   empty is low and leaves at a rising edge with pop high
// every item gives exactly one result beat, in order of acceptance
// each item goes through the command queue, execute register and result queue in turn
// throughput: one item per cycle while the receiver takes results, set by the single
//   execute stage that touches the port registers and the one ram port
// a two-entry command queue parts the decode front from the execute back, and a
//   two-entry result queue parts the execute stage from the receiver
// when the receiver stalls, results pile up in the result queue, then the execute
//   stage holds, then the command queue fills and full rises
// reset (rst, synchronous) empties both queues, clears the port registers and the
//   pending key, and sets the key latch to a space; ram contents are not cleared
//   and a ram byte reads back only after it has been written
module keyboard_display_port_bus_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  kdp_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output kdp_pkg::result_t result
);

  logic          cmd_valid;
  logic          cmd_ready;
  kdp_pkg::cmd_t cmd;

  // decode and queue
  kdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // execute and hand out results
  kdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

@@ src/kdp_checker.sv @@
// port-level checker for the keyboard and display port bus unit
`include "keyboard_display_port_bus_unit_defines.svh"

module kdp_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input kdp_pkg::result_t result
);

  `KDP_ASSERT_NEXT(a_reset_clear, clk, rst, empty && !full, "queues not empty after reset")
  `KDP_ASSERT_IMP(a_print_only, clk, rst, !empty && result.print_valid, (result.read_data == 8'd0) && (result.print_char != kdp_pkg::CHAR_DEL), "bad print beat")
  `KDP_ASSERT_IMP(a_no_char, clk, rst, !empty && !result.print_valid, result.print_char == 7'd0, "char without print_valid")
  `KDP_ASSERT_IMP(a_hold, clk, rst, $past(!empty && !pop && !rst), !empty && $stable(result), "stalled result changed")

endmodule

bind keyboard_display_port_bus_unit kdp_checker u_kdp_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

@@ verif/keyboard_display_port_bus_unit_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the keyboard and display port bus unit
module keyboard_display_port_bus_unit_tb;
  import kdp_pkg::*;

  // run shape
  localparam int RANDOM_ITEMS   = 1300;
  localparam int STALL_LIMIT    = 1000;  // cycles with no beat on either side
  localparam int RX_HOLD_AT     = 300;   // result count that starts the long receiver hold
  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 8;     // margin for a stray beat after the last reply
  localparam int RESET_CYCLES   = 5;
  localparam int SIDE_TX        = 0;
  localparam int SIDE_RX        = 1;

  logic    clk  = 1'b0;
  logic    rst  = 1'b1;
  logic    push = 1'b0;
  logic    pop  = 1'b0;
  logic    full;
  logic    empty;
  item_t   item = '0;
  result_t result;

  keyboard_display_port_bus_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // bus operations waiting to be offered, replies waiting to come back
  item_t   queued_bus_ops [$];
  result_t bus_replies_due [$];

  // generator side record of ram bytes that hold data, so reads only hit those
  bit ram_written [int];
  int written_list [$];
  int items_made = 0;

  // shadow of the port registers, key latch and ram
  logic [7:0] kbd_data_q  = '0;
  logic [7:0] kbd_ctrl_q  = '0;
  logic [7:0] disp_data_q = '0;
  logic [7:0] disp_ctrl_q = '0;
  logic       key_waiting = 1'b0;
  logic [7:0] key_held    = KEY_RESET;
  logic [7:0] ram_image [int];

  // handshake bookkeeping between the monitor (rising edge) and driver (falling edge)
  bit in_taken     = 1'b0;
  bit out_taken    = 1'b0;
  int results_done = 0;
  int idle_cycles  = 0;
  int mismatches   = 0;

  // idling state
  int tx_wait      = 0;
  int rx_wait      = 0;
  int rx_hold_left = 0;
  bit hold_started = 1'b0;
  int calm_left [2] = '{0, 0};

  function automatic logic is_port_addr(logic [15:0] a);
    return (a[15:8] == PORT_PAGE) && (a[7:2] == PORT_ROW);
  endfunction

  function automatic logic [15:0] port_addr(port_t p);
    return {PORT_PAGE, PORT_ROW, p};
  endfunction

  // reply of the bus to one operation, advancing the shadow state
  function automatic result_t bus_reply_for(item_t it);
    result_t    res;
    logic [7:0] k;
    logic [6:0] c;
    int         idx;
    res = '0;
    idx = int'(it.address[ADDR_BITS-1:0]);
    case (op_t'(it.func))
      OP_WRITE: begin
        if (is_port_addr(it.address)) begin
          case (port_t'(it.address[1:0]))
            PORT_KDATA: kbd_data_q = it.write_data;
            PORT_KCTRL: kbd_ctrl_q = it.write_data;
            PORT_DDATA: disp_data_q = it.write_data | BIT7;  // display write marks a char due
            PORT_DCTRL: disp_ctrl_q = it.write_data;
          endcase
        end else begin
          ram_image[idx] = it.write_data;
        end
      end
      OP_READ: begin
        if (is_port_addr(it.address)) begin
          case (port_t'(it.address[1:0]))
            PORT_KDATA: begin
              res.read_data = kbd_data_q;
              kbd_ctrl_q = kbd_ctrl_q & ~BIT7;  // reading the key drops ready
            end
            PORT_KCTRL: res.read_data = kbd_ctrl_q;
            PORT_DDATA: res.read_data = disp_data_q;
            PORT_DCTRL: res.read_data = disp_ctrl_q;
          endcase
        end else begin
          res.read_data = ram_image.exists(idx) ? ram_image[idx] : 8'h00;
        end
      end
      OP_KEY: begin
        key_held = it.key_char;
        key_waiting = 1'b1;
      end
      OP_TICK: begin
        // pending key lands only while ready is clear, otherwise it is lost
        if (key_waiting) begin
          key_waiting = 1'b0;
          if ((kbd_ctrl_q & BIT7) == '0) begin
            k = key_held;
            if (k >= CHAR_LOWER_A && k <= CHAR_LOWER_Z) k = k - CASE_OFFSET;
            kbd_data_q = k | BIT7;
            kbd_ctrl_q = kbd_ctrl_q | BIT7;
          end
        end
        // due display char goes out if printable, backspace or return, never delete
        if (disp_data_q[7]) begin
          c = disp_data_q[6:0];
          if ((c > CHAR_CTRL_MAX || c == CHAR_BS || c == CHAR_CR) && c != CHAR_DEL) begin
            res.print_valid = 1'b1;
            res.print_char = c;
          end
          disp_data_q[7] = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  // per-beat wait, with occasional calm stretches of back-to-back beats
  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic add_item(input op_t op, input logic [15:0] a, input logic [7:0] wd,
                          input logic [7:0] kc);
    item_t it;
    int    idx;
    it.func = op;
    it.address = a;
    it.write_data = wd;
    it.key_char = kc;
    idx = int'(a[ADDR_BITS-1:0]);
    if (op == OP_WRITE && !is_port_addr(a) && !ram_written.exists(idx)) begin
      ram_written[idx] = 1'b1;
      written_list.push_back(idx);
    end
    queued_bus_ops.push_back(it);
    items_made++;
  endtask

  // one random operation or a short well-formed sequence with random content
  task automatic add_random_item();
    int          kind;
    int          idx;
    logic [15:0] a;
    logic [7:0]  wd;
    logic [7:0]  kc;
    port_t       p;
    kind = $urandom_range(0, 19);
    a = 16'($urandom_range(0, 65535));
    wd = 8'($urandom_range(0, 255));
    kc = 8'($urandom_range(0, 255));
    p = port_t'($urandom_range(0, 3));
    case (kind)
      0, 1, 2: add_item(OP_WRITE, a, wd, kc);
      // addresses right around the port window, mostly ram
      3: add_item(OP_WRITE, {PORT_PAGE, 6'(PORT_ROW + $urandom_range(0, 2) - 1),
                             2'($urandom_range(0, 3))}, wd, kc);
      4, 5, 6: begin
        if (written_list.size() != 0) begin
          idx = written_list[$urandom_range(0, written_list.size() - 1)];
          a[ADDR_BITS-1:0] = idx[ADDR_BITS-1:0];
          add_item(OP_READ, a, wd, kc);
        end else begin
          add_item(OP_WRITE, a, wd, kc);
        end
      end
      7, 8: add_item(OP_WRITE, port_addr(p), wd, kc);
      9, 10, 11: add_item(OP_READ, port_addr(p), wd, kc);
      12, 13: begin
        // half the keys near or in the lower-case range
        if ($urandom_range(0, 1) != 0)
          kc = 8'($urandom_range(CHAR_LOWER_A - 1, CHAR_LOWER_Z + 1));
        add_item(OP_KEY, a, wd, kc);
      end
      14, 15, 16: add_item(OP_TICK, a, wd, kc);
      17: begin
        // type a key, let it land, poll ready, then take it
        add_item(OP_KEY, a, wd, kc);
        add_item(OP_TICK, a, wd, kc);
        add_item(OP_READ, port_addr(PORT_KCTRL), wd, kc);
        add_item(OP_READ, port_addr(PORT_KDATA), wd, kc);
      end
      18: begin
        // print one char and look at the display register afterwards
        add_item(OP_WRITE, port_addr(PORT_DDATA), wd, kc);
        add_item(OP_TICK, a, wd, kc);
        add_item(OP_READ, port_addr(PORT_DDATA), wd, kc);
      end
      default: begin
        // force ready either way, then deliver a key into it
        add_item(OP_WRITE, port_addr(PORT_KCTRL), wd, kc);
        add_item(OP_KEY, a, wd, kc);
        add_item(OP_TICK, a, wd, kc);
        add_item(OP_READ, port_addr(PORT_KDATA), wd, kc);
      end
    endcase
  endtask

  task automatic fill_random(input int count);
    int goal;
    goal = items_made + count;
    while (items_made < goal) add_random_item();
  endtask

  // sender pause: nothing new until every reply owed has come back
  task automatic wait_for_drain();
    while (queued_bus_ops.size() != 0 || bus_replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected rd=%h pv=%b pc=%h, got rd=%h pv=%b pc=%h", $time, what,
               want.read_data, want.print_valid, want.print_char,
               got.read_data, got.print_valid, got.print_char);
  endtask

  // monitor: samples both handshakes on the rising edge
  always @(posedge clk) begin : monitor
    result_t want;
    logic    any_beat;
    any_beat = 1'b0;
    if (!rst) begin
      // result beat first: it can never belong to an item taken on this same edge
      if (pop && !empty) begin
        any_beat = 1'b1;
        results_done++;
        out_taken = 1'b1;
        if (bus_replies_due.size() == 0) begin
          report_mismatch("result beat with nothing owed", '0, result);
        end else begin
          want = bus_replies_due.pop_front();
          if (result.read_data !== want.read_data || result.print_valid !== want.print_valid ||
              result.print_char !== want.print_char)
            report_mismatch("result mismatch", want, result);
        end
      end
      if (push && !full) begin
        any_beat = 1'b1;
        in_taken = 1'b1;
        bus_replies_due.push_back(bus_reply_for(item));
      end
    end
    idle_cycles = any_beat ? 0 : idle_cycles + 1;
  end

  // long receiver hold, started once and counted down here while the sender keeps going
  always @(posedge clk) begin : rx_hold
    if (!rst) begin
      if (!hold_started && results_done >= RX_HOLD_AT) begin
        hold_started <= 1'b1;
        rx_hold_left <= RX_HOLD_CYCLES;
      end else if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
      end
    end
  end

  // driver: both sides change on the falling edge, one update per signal per edge
  always @(negedge clk) begin : driver
    logic next_push;
    logic next_pop;
    next_push = push;
    next_pop = pop;
    if (!rst) begin
      // input side
      if (in_taken) begin
        in_taken = 1'b0;
        void'(queued_bus_ops.pop_front());
        tx_wait = draw_wait(SIDE_TX);
        next_push = 1'b0;
      end
      if (!next_push) begin
        // keep offering while the receiver holds off so the block backs up
        if (rx_hold_left > 0) tx_wait = 0;
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (queued_bus_ops.size() != 0) begin
          item <= queued_bus_ops[0];
          next_push = 1'b1;
        end
      end
      // result side
      if (out_taken) begin
        out_taken = 1'b0;
        rx_wait = draw_wait(SIDE_RX);
      end
      if (rx_hold_left > 0) begin
        next_pop = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        next_pop = 1'b0;
      end else begin
        next_pop = 1'b1;
      end
    end
    push <= next_push;
    pop <= next_pop;
  end

  // stimulus: directed checks, then two random halves with a full drain between
  initial begin
    // reset state, no key pending yet
    add_item(OP_READ, port_addr(PORT_KDATA), '0, '0);
    add_item(OP_TICK, '0, '0, '0);
    // lower-case key lands upper-cased with ready raised
    add_item(OP_KEY, '0, '0, CHAR_LOWER_A);
    add_item(OP_TICK, '0, '0, '0);
    add_item(OP_READ, port_addr(PORT_KCTRL), '0, '0);
    // ready still set, so this key is lost
    add_item(OP_KEY, '0, '0, CHAR_LOWER_Z);
    add_item(OP_TICK, '0, '0, '0);
    // reading key data drops ready
    add_item(OP_READ, port_addr(PORT_KDATA), '0, '0);
    // second press overwrites the first before the tick
    add_item(OP_KEY, '0, '0, 8'h71);
    add_item(OP_KEY, '0, '0, 8'hFF);
    add_item(OP_TICK, '0, '0, '0);
    // delete is never printed
    add_item(OP_WRITE, port_addr(PORT_DDATA), 8'h7F, '0);
    add_item(OP_TICK, '0, '0, '0);
    // backspace is printed
    add_item(OP_WRITE, port_addr(PORT_DDATA), 8'h08, '0);
    add_item(OP_TICK, '0, '0, '0);
    // other control chars are dropped, bit 7 set on write
    add_item(OP_WRITE, port_addr(PORT_DDATA), 8'h9F, '0);
    add_item(OP_TICK, '0, '0, '0);
    // carriage return is printed, then bit 7 reads back clear
    add_item(OP_WRITE, port_addr(PORT_DDATA), 8'h0D, '0);
    add_item(OP_TICK, '0, '0, '0);
    add_item(OP_READ, port_addr(PORT_DDATA), '0, '0);
    // ram at both ends of the address space
    add_item(OP_WRITE, 16'h0000, 8'h00, '0);
    add_item(OP_WRITE, 16'hFFFF, 8'hFF, '0);
    add_item(OP_READ, 16'h0000, '0, '0);
    add_item(OP_READ, 16'hFFFF, '0, '0);
    add_item(OP_WRITE, port_addr(PORT_DCTRL), 8'hFF, '0);
    add_item(OP_READ, port_addr(PORT_DCTRL), '0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait_for_drain();
    fill_random(RANDOM_ITEMS / 2);
    wait_for_drain();
    fill_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
    wait_for_drain();
    // any stray beat after the last reply gets caught here
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("keyboard_display_port_bus_unit: match");
    else
      $display("keyboard_display_port_bus_unit: mismatch");
    $finish;
  end

  // watchdog: too long without a beat on either side means the block hung
  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("keyboard_display_port_bus_unit: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/kdp_pkg.sv
src/kdp_ram.sv
src/kdp_front.sv
src/kdp_back.sv
src/keyboard_display_port_bus_unit.sv
src/kdp_checker.sv
verif/keyboard_display_port_bus_unit_tb.sv
